// ----- hdl/bfa_pkg.sv -----
// Shared types and constants for the bitmap frame allocator.
// Used by the top level and by its checker; no dependencies.
package bfa_pkg;

  localparam int NUM_FRAMES_DEF = 4096;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  // Largest value that the 13-bit frame count register can hold
  localparam int TOTAL_MAX = 8191;

  typedef enum logic [1:0] {
    OP_ALLOC          = 2'd0,
    OP_FREE_RUN       = 2'd1,
    OP_FREE_REGION    = 2'd2,
    OP_RESERVE_REGION = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_ZERO_LEN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAP_END      = 2'd0,
    CFG_TOTAL_FRAMES = 2'd1
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RANGE,
    S_SCAN,
    S_WRITE,
    S_MUL,
    S_FINISH
  } state_t;

endpackage

// ----- hdl/bitmap_frame_allocator.sv -----
// Bitmap page-frame allocator: first-fit run search, run free, region free/reserve.
// Depends on bfa_pkg and bfa_ram (bitmap store).
//
// Request channel: drive op, address, run_frames and region_bytes with start high;
//   the transaction is taken at a rising edge where start is high and busy is low.
// Result channel: done pulses for one cycle with status, result_address and
//   free_frames. The receiver cannot stall; done comes in the first cycle that busy
//   is low again, so the next request may be taken there.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Index 0 is the base byte address, index 1 the frame count.
// States from acceptance to done, which FINISH raises:
//   zero-length allocate or free run, or short-of-space allocate: FINISH
//   allocate: SCAN, WRITE one word a cycle, MUL and FINISH, or SCAN and FINISH when no run
//     fits; the scan steps over each free or used stretch in each word up to the
//     run found.
//   free run, free or reserve region: RANGE, WRITE per word (none for an empty range), FINISH.
//   Page size and word width are powers of two, so address division is a shift.
// Reset: every frame is marked used by a sweep that writes all MAP_WORDS bitmap words
//   (128 by default), one per cycle, with busy high; configuration writes are still
//   taken during the sweep.
module bitmap_frame_allocator #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = bfa_pkg::PAGE_BYTES_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] address,
  input  logic [12:0] run_frames,
  input  logic [31:0] region_bytes,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] result_address,
  output logic [12:0] free_frames,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bfa_pkg::*;

  localparam int MAP_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW          = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int FW          = $clog2(NUM_FRAMES + WORD_BITS + 1);
  localparam int PW          = $clog2(WORD_BITS);
  localparam int PSH         = $clog2(PAGE_BYTES);
  localparam int LW          = 14;
  localparam int TOTAL_RESET = NUM_FRAMES < TOTAL_MAX ? NUM_FRAMES : TOTAL_MAX;

  // ---------------------------------------------------------------- helpers
  function automatic logic [WORD_BITS-1:0] below(input logic [FW-1:0] n);
    logic [WORD_BITS-1:0] m;
    for (int j = 0; j < WORD_BITS; j++) begin
      m[j] = (FW'(j) < n);
    end
    return m;
  endfunction

  function automatic logic [PW:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [PW:0] idx;
    idx = (PW+1)'(WORD_BITS);
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (v[j]) begin
        idx = (PW+1)'(j);
      end
    end
    return idx;
  endfunction

  function automatic logic [PW:0] ones_count(input logic [WORD_BITS-1:0] v);
    logic [PW:0] c;
    c = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      c = c + (PW+1)'(v[j]);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- registers
  state_t            state, state_next;
  status_t           status_r, status_next;
  logic [12:0]       run_r, run_next;
  logic              mark_used, mark_used_next;
  logic              alloc_ok, alloc_ok_next;
  logic [AW-1:0]     word_idx, word_idx_next;
  logic [FW-1:0]     word_base, word_base_next;
  logic [PW-1:0]     pos, pos_next;
  logic [LW-1:0]     len, len_next;
  logic [AW-1:0]     rs_word, rs_word_next;
  logic [PW-1:0]     rs_bit, rs_bit_next;
  logic [FW-1:0]     rs_frame, rs_frame_next;
  logic [31:0]       start_frame, start_frame_next;
  logic [31:0]       count, count_next;
  logic [FW-1:0]     end_frame, end_frame_next;
  logic [PW-1:0]     cur_lo, cur_lo_next;
  logic [FW-1:0]     used_count, used_count_next;
  logic [31:0]       prod, prod_next;
  logic              done_next;
  logic [1:0]        status_next_out;
  logic [31:0]       result_next;
  logic [12:0]       free_next;
  logic [31:0]       map_end;
  logic [12:0]       total_r;

  // ---------------------------------------------------------------- RAM
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] rdata;

  // Read at the next word index so the word is on rdata as soon as word_idx holds it
  bfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(word_idx),
    .wdata(ram_wdata),
    .raddr(word_idx_next),
    .rdata(rdata)
  );

  // ---------------------------------------------------------------- datapath
  logic [FW-1:0]        lim;
  logic [FW-1:0]        free_now;
  logic [FW-1:0]        lim_rem;
  logic [WORD_BITS-1:0] fv;
  logic                 cur_free;
  logic [WORD_BITS-1:0] srch;
  logic [PW:0]          nxt;
  logic [PW:0]          seg;
  logic [LW-1:0]        newlen;
  logic                 word_end;
  logic                 last_word;
  logic [AW-1:0]        eff_word;
  logic [PW-1:0]        eff_bit;
  logic [FW-1:0]        eff_frame;
  logic [WORD_BITS-1:0] wmask;
  logic [WORD_BITS-1:0] wnew;
  logic [WORD_BITS-1:0] wchg;
  logic [PW:0]          wcnt;
  logic                 write_last;
  logic [32:0]          end_sum;
  logic [32:0]          end_clip;
  logic                 range_empty;

  always_comb begin
    lim      = (32'(total_r) < 32'(NUM_FRAMES)) ? FW'(total_r) : FW'(NUM_FRAMES);
    free_now = (lim > used_count) ? lim - used_count : '0;

    // Scan: free bits below the limit, then the next change from the current bit
    lim_rem   = (lim > word_base) ? lim - word_base : '0;
    fv        = ~rdata & below(lim_rem);
    cur_free  = fv[pos];
    srch      = (cur_free ? ~fv : fv) & ({WORD_BITS{1'b1}} << pos);
    nxt       = first_set(srch);
    seg       = nxt - {1'b0, pos};
    newlen    = len + LW'(seg);
    word_end  = (nxt == (PW+1)'(WORD_BITS));
    last_word = (word_base + FW'(WORD_BITS) >= lim);
    eff_word  = (len == '0) ? word_idx : rs_word;
    eff_bit   = (len == '0) ? pos : rs_bit;
    eff_frame = (len == '0) ? word_base + FW'(pos) : rs_frame;

    // Range write: bits from cur_lo up to the end frame within this word
    wmask      = below(end_frame - word_base) & ({WORD_BITS{1'b1}} << cur_lo);
    wnew       = mark_used ? (rdata | wmask) : (rdata & ~wmask);
    wchg       = wmask & (mark_used ? ~rdata : rdata);
    wcnt       = ones_count(wchg);
    write_last = (word_base + FW'(WORD_BITS) >= end_frame);

    end_sum     = {1'b0, start_frame} + {1'b0, count};
    end_clip    = (end_sum < 33'(lim)) ? end_sum : 33'(lim);
    range_empty = ({1'b0, start_frame} >= end_clip);
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next       = state;
    status_next      = status_r;
    run_next         = run_r;
    mark_used_next   = mark_used;
    alloc_ok_next    = alloc_ok;
    word_idx_next    = word_idx;
    word_base_next   = word_base;
    pos_next         = pos;
    len_next         = len;
    rs_word_next     = rs_word;
    rs_bit_next      = rs_bit;
    rs_frame_next    = rs_frame;
    start_frame_next = start_frame;
    count_next       = count;
    end_frame_next   = end_frame;
    cur_lo_next      = cur_lo;
    used_count_next  = used_count;
    prod_next        = prod;
    done_next        = 1'b0;
    status_next_out  = status;
    result_next      = result_address;
    free_next        = free_frames;
    ram_we           = 1'b0;
    ram_wdata        = wnew;

    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = {WORD_BITS{1'b1}};
        if (word_idx == AW'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end else begin
          word_idx_next = word_idx + AW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          run_next         = run_frames;
          status_next      = STAT_OK;
          alloc_ok_next    = 1'b0;
          mark_used_next   = (op == OP_ALLOC) || (op == OP_RESERVE_REGION);
          unique case (op_t'(op))
            OP_ALLOC: begin
              if (run_frames == '0) begin
                status_next = STAT_ZERO_LEN;
                state_next  = S_FINISH;
              end else if (32'(free_now) < 32'(run_frames)) begin
                status_next = STAT_NO_SPACE;
                state_next  = S_FINISH;
              end else begin
                word_idx_next  = '0;
                word_base_next = '0;
                pos_next       = '0;
                len_next       = '0;
                state_next     = S_SCAN;
              end
            end
            OP_FREE_RUN: begin
              if (run_frames == '0) begin
                status_next = STAT_ZERO_LEN;
                state_next  = S_FINISH;
              end else begin
                start_frame_next = (address - map_end) >> PSH;
                count_next       = 32'(run_frames);
                state_next       = S_RANGE;
              end
            end
            OP_FREE_REGION, OP_RESERVE_REGION: begin
              start_frame_next = address >> PSH;
              count_next       = region_bytes >> PSH;
              state_next       = S_RANGE;
            end
          endcase
        end
      end

      S_RANGE: begin
        if (range_empty) begin
          state_next = S_FINISH;
        end else begin
          // Word index from the upper frame bits, first bit from the lower ones
          end_frame_next = FW'(end_clip);
          word_idx_next  = AW'(start_frame >> PW);
          cur_lo_next    = start_frame[PW-1:0];
          word_base_next = FW'(start_frame) - FW'(start_frame[PW-1:0]);
          state_next     = S_WRITE;
        end
      end

      S_SCAN: begin
        if (cur_free) begin
          if (len == '0) begin
            rs_word_next  = word_idx;
            rs_bit_next   = pos;
            rs_frame_next = eff_frame;
          end
          if (newlen >= LW'(run_r)) begin
            // Run complete: mark it used from its first frame
            alloc_ok_next  = 1'b1;
            rs_frame_next  = eff_frame;
            word_idx_next  = eff_word;
            cur_lo_next    = eff_bit;
            word_base_next = eff_frame - FW'(eff_bit);
            end_frame_next = eff_frame + FW'(run_r);
            state_next     = S_WRITE;
          end else if (word_end) begin
            if (last_word) begin
              status_next = STAT_NO_SPACE;
              state_next  = S_FINISH;
            end else begin
              len_next       = newlen;
              pos_next       = '0;
              word_idx_next  = word_idx + AW'(1);
              word_base_next = word_base + FW'(WORD_BITS);
            end
          end else begin
            len_next = newlen;
            pos_next = PW'(nxt);
          end
        end else begin
          // Used bit breaks any run; skip to the next free bit
          len_next = '0;
          if (word_end) begin
            if (last_word) begin
              status_next = STAT_NO_SPACE;
              state_next  = S_FINISH;
            end else begin
              pos_next       = '0;
              word_idx_next  = word_idx + AW'(1);
              word_base_next = word_base + FW'(WORD_BITS);
            end
          end else begin
            pos_next = PW'(nxt);
          end
        end
      end

      S_WRITE: begin
        ram_we          = 1'b1;
        cur_lo_next     = '0;
        used_count_next = mark_used ? used_count + FW'(wcnt) : used_count - FW'(wcnt);
        if (write_last) begin
          state_next = alloc_ok ? S_MUL : S_FINISH;
        end else begin
          word_idx_next  = word_idx + AW'(1);
          word_base_next = word_base + FW'(WORD_BITS);
        end
      end

      S_MUL: begin
        prod_next  = 32'(32'(rs_frame) * 32'(PAGE_BYTES));
        state_next = S_FINISH;
      end

      S_FINISH: begin
        done_next       = 1'b1;
        status_next_out = status_r;
        result_next     = alloc_ok ? map_end + prod : '0;
        free_next       = 13'(free_now);
        state_next      = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      word_idx   <= '0;
      used_count <= FW'(NUM_FRAMES);
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      word_idx   <= word_idx_next;
      used_count <= used_count_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status_r       <= status_next;
    run_r          <= run_next;
    mark_used      <= mark_used_next;
    alloc_ok       <= alloc_ok_next;
    word_base      <= word_base_next;
    pos            <= pos_next;
    len            <= len_next;
    rs_word        <= rs_word_next;
    rs_bit         <= rs_bit_next;
    rs_frame       <= rs_frame_next;
    start_frame    <= start_frame_next;
    count          <= count_next;
    end_frame      <= end_frame_next;
    cur_lo         <= cur_lo_next;
    prod           <= prod_next;
    status         <= status_next_out;
    result_address <= result_next;
    free_frames    <= free_next;
  end

  // Configuration registers; unknown indices are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      map_end <= '0;
      total_r <= 13'(TOTAL_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAP_END:      map_end <= cfg_data;
        CFG_TOTAL_FRAMES: total_r <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

endmodule

// ----- hdl/bfa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Holds the frame bitmap words; no dependencies.
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bfa_checker.sv -----
// Port-level checks for the bitmap frame allocator, bound to the top level.
// Depends on bfa_pkg for the status codes.
module bfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] result_address
);
  import bfa_pkg::*;

  // A result only appears once the block is free to take the next transaction
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Every accepted transaction keeps the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_OK || status == STAT_NO_SPACE || status == STAT_ZERO_LEN))
    else $error("undefined status code");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (result_address == 32'd0))
    else $error("failed request returned an address");

  // One result per transaction: the result strobe is never held high
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .result_address(result_address)
);
